[rtl/cibb_pkg.sv]
// shared constants for the content index bitmap builder
package cibb_pkg;

  localparam int BLOCK_SIZE_DEF = 1024;
  localparam int INDEX_BITS_DEF = 16;
  localparam int MAP_WORD_BITS  = 64;
  localparam int WORD_NUM_BITS  = 4;
  localparam int SEG_CNT_BITS   = 7;

  function automatic int pad_bytes(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

[rtl/cibb_ram.sv]
// generic single-write, single-read ram with registered read data
module cibb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/content_index_bitmap_builder_core.sv]
// top level of the content index bitmap builder
// an index that stays in the open segment is read in ST_IDLE, then its map word is written back in ST_RMW
// a segment flush reads each map word (registered ram read), then loads it into the output and clears it,
// then ST_SETNEW starts the new segment unless the run ends; stalls on the output stretch each word
// after reset the map ram is cleared, one word a cycle, with in_tready low
// each result passes the registered ram read, then the output register; the output register frees the input side
module content_index_bitmap_builder_core #(
  parameter int BLOCK_SIZE = cibb_pkg::BLOCK_SIZE_DEF,
  parameter int INDEX_BITS = cibb_pkg::INDEX_BITS_DEF,
  localparam int IN_W  = cibb_pkg::pad_bytes(INDEX_BITS),
  localparam int OUT_W = cibb_pkg::pad_bytes(INDEX_BITS + cibb_pkg::WORD_NUM_BITS +
                                             cibb_pkg::MAP_WORD_BITS + cibb_pkg::SEG_CNT_BITS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // content_index
  input  logic             in_tlast,   // final_index
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // segment_base, word_number, bitmap_word, segments_so_far
  output logic             out_tlast   // end_of_run
);

  localparam int MAP_WORDS = BLOCK_SIZE / 64;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int MW        = cibb_pkg::MAP_WORD_BITS;
  localparam int SW        = cibb_pkg::SEG_CNT_BITS;
  localparam int NW        = cibb_pkg::WORD_NUM_BITS;

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RMW    = 3'd2;
  localparam logic [2:0] ST_SETNEW = 3'd3;
  localparam logic [2:0] ST_ERD    = 3'd4;
  localparam logic [2:0] ST_ECAP   = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [AW-1:0]         word_r, word_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic                  fin_r, fin_nxt;
  logic                  fin_emit_r, fin_emit_nxt;
  logic                  open_r, open_nxt;
  logic [INDEX_BITS-1:0] base_r, base_nxt;
  logic [INDEX_BITS:0]   bound_r, bound_nxt;
  logic [SW-1:0]         total_r, total_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [INDEX_BITS-1:0] out_base_r, out_base_nxt;
  logic [NW-1:0]         out_word_r, out_word_nxt;
  logic [MW-1:0]         out_map_r, out_map_nxt;
  logic [SW-1:0]         out_seg_r, out_seg_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [MW-1:0]         ram_wdata, ram_rdata;

  logic [INDEX_BITS-1:0] in_idx;
  logic                  start;
  logic [AW-1:0]         in_addr, idx_addr;
  logic [MW-1:0]         bit_mask;
  logic [INDEX_BITS-1:0] new_base;
  logic                  word_last;

  assign in_idx    = in_tdata[INDEX_BITS-1:0];
  assign start     = !open_r || ({1'b0, in_idx} >= bound_r);
  assign in_addr   = AW'(in_idx >> 6) & AW'(MAP_WORDS - 1);
  assign idx_addr  = AW'(idx_r >> 6) & AW'(MAP_WORDS - 1);
  assign bit_mask  = MW'(1) << idx_r[5:0];
  assign new_base  = idx_r & ~INDEX_BITS'(BLOCK_SIZE - 1);
  assign word_last = (word_r == AW'(MAP_WORDS - 1));

  cibb_ram #(
    .WIDTH(MW),
    .DEPTH(MAP_WORDS)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    idx_nxt       = idx_r;
    fin_nxt       = fin_r;
    fin_emit_nxt  = fin_emit_r;
    open_nxt      = open_r;
    base_nxt      = base_r;
    bound_nxt     = bound_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_base_nxt  = out_base_r;
    out_word_nxt  = out_word_r;
    out_map_nxt   = out_map_r;
    out_seg_nxt   = out_seg_r;
    out_last_nxt  = out_last_r;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = word_r;
    ram_wdata     = '0;
    ram_raddr     = word_r;

    unique case (state_r)
      ST_CLR: begin
        ram_we   = 1'b1;
        word_nxt = word_r + AW'(1);
        if (word_last) begin
          word_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        ram_raddr = in_addr;
        if (in_tvalid) begin
          idx_nxt = in_idx;
          fin_nxt = in_tlast;
          if (!start) begin
            state_nxt = ST_RMW;
          end else if (open_r) begin
            fin_emit_nxt = 1'b0;
            word_nxt     = '0;
            state_nxt    = ST_ERD;
          end else begin
            state_nxt = ST_SETNEW;
          end
        end
      end
      ST_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = idx_addr;
        ram_wdata = ram_rdata | bit_mask;
        if (fin_r) begin
          fin_emit_nxt = 1'b1;
          word_nxt     = '0;
          state_nxt    = ST_ERD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SETNEW: begin
        // map was cleared by the reset clear or the flush, so the word holds only the new bit
        ram_we    = 1'b1;
        ram_waddr = idx_addr;
        ram_wdata = bit_mask;
        base_nxt  = new_base;
        bound_nxt = {1'b0, new_base} + (INDEX_BITS + 1)'(BLOCK_SIZE);
        open_nxt  = 1'b1;
        total_nxt = total_r + SW'(1);
        if (fin_r) begin
          fin_emit_nxt = 1'b1;
          word_nxt     = '0;
          state_nxt    = ST_ERD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERD: begin
        ram_raddr = word_r;
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_ECAP;
        end
      end
      ST_ECAP: begin
        out_valid_nxt = 1'b1;
        out_base_nxt  = base_r;
        out_word_nxt  = NW'(word_r);
        out_map_nxt   = ram_rdata;
        out_seg_nxt   = total_r;
        out_last_nxt  = word_last && (fin_emit_r || !fin_r);
        ram_we        = 1'b1;
        ram_waddr     = word_r;
        word_nxt      = word_r + AW'(1);
        if (word_last) begin
          word_nxt = '0;
          if (fin_emit_r) begin
            open_nxt  = 1'b0;
            base_nxt  = '0;
            bound_nxt = '0;
            total_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SETNEW;
          end
        end else begin
          state_nxt = ST_ERD;
        end
      end
      default: begin
        state_nxt = ST_CLR;
        word_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      word_r      <= '0;
      fin_r       <= 1'b0;
      fin_emit_r  <= 1'b0;
      open_r      <= 1'b0;
      base_r      <= '0;
      bound_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      fin_r       <= fin_nxt;
      fin_emit_r  <= fin_emit_nxt;
      open_r      <= open_nxt;
      base_r      <= base_nxt;
      bound_r     <= bound_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    out_base_r <= out_base_nxt;
    out_word_r <= out_word_nxt;
    out_map_r  <= out_map_nxt;
    out_seg_r  <= out_seg_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_seg_r, out_map_r, out_word_r, out_base_r});

endmodule

[rtl/cibb_checker.sv]
// port-level checks for the content index bitmap builder, bound to the top level
module cibb_checker #(
  parameter int BLOCK_SIZE = cibb_pkg::BLOCK_SIZE_DEF,
  parameter int INDEX_BITS = cibb_pkg::INDEX_BITS_DEF,
  localparam int OUT_W = cibb_pkg::pad_bytes(INDEX_BITS + cibb_pkg::WORD_NUM_BITS +
                                             cibb_pkg::MAP_WORD_BITS + cibb_pkg::SEG_CNT_BITS)
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  localparam int NW  = cibb_pkg::WORD_NUM_BITS;
  localparam int SW  = cibb_pkg::SEG_CNT_BITS;
  localparam int WLO = INDEX_BITS;
  localparam int SLO = INDEX_BITS + NW + cibb_pkg::MAP_WORD_BITS;

  logic [NW-1:0] word_num;
  logic [SW-1:0] seg_cnt;

  assign word_num  = out_tdata[WLO +: NW];
  assign seg_cnt   = out_tdata[SLO +: SW];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output transaction changed");

  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> word_num == NW'(BLOCK_SIZE / 64 - 1))
    else $error("end of run on a word that is not the last of its segment");

  a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> seg_cnt != '0)
    else $error("segment word with zero segment count");

  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted in back-to-back cycles");

endmodule

bind content_index_bitmap_builder_core cibb_checker #(
  .BLOCK_SIZE(BLOCK_SIZE),
  .INDEX_BITS(INDEX_BITS)
) u_cibb_checker (.*);
